### rtl/timq_pkg.sv
// Shared types and constants for the timed event queue.
// Command codes, cell control word and controller states.
// No dependencies.
package timq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int ID_BITS   = 16;
	localparam int TIME_BITS = 32;
	localparam int CMD_BITS  = 3;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_INSERT        = 3'd0,
		CMD_INSERT_FUTURE = 3'd1,
		CMD_REMOVE_AT     = 3'd2,
		CMD_LIST_ALL      = 3'd3,
		CMD_LIST_AT       = 3'd4,
		CMD_ADVANCE       = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     keep;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

### rtl/timq_cell.sv
// One slot of the sorted entry chain: holds a time and an event id.
// Takes its neighbors' entries on insert and shift; depends on timq_pkg.
module timq_cell import timq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int IDX   = 0,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  cell_ctrl_t           ctrl,
	input  logic [CNT_W-1:0]     count,
	input  logic [IDX_W-1:0]     wp,
	input  logic [TIME_BITS-1:0] ins_time,
	input  logic [ID_BITS-1:0]   ins_id,
	input  logic                 left_le,
	input  logic [TIME_BITS-1:0] left_time,
	input  logic [ID_BITS-1:0]   left_id,
	input  logic [TIME_BITS-1:0] right_time,
	input  logic [ID_BITS-1:0]   right_id,
	input  logic [TIME_BITS-1:0] head_time,
	input  logic [ID_BITS-1:0]   head_id,
	output logic [TIME_BITS-1:0] cell_time,
	output logic [ID_BITS-1:0]   cell_id,
	output logic                 le
);

	logic [TIME_BITS-1:0] time_q;
	logic [ID_BITS-1:0]   id_q;
	logic                 live;

	assign live      = CNT_W'(IDX) < count;
	assign le        = live && (time_q <= ins_time);
	assign cell_time = time_q;
	assign cell_id   = id_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_INSERT: begin
				// keep entries at or before the new time, open a gap after them
				if (!le) begin
					if (left_le) begin
						time_q <= ins_time;
						id_q   <= ins_id;
					end else begin
						time_q <= left_time;
						id_q   <= left_id;
					end
				end
			end
			CELL_SHIFT: begin
				// advance toward the head; the tail slot recycles a kept head
				if (ctrl.keep && (wp == IDX_W'(IDX))) begin
					time_q <= head_time;
					id_q   <= head_id;
				end else begin
					time_q <= right_time;
					id_q   <= right_id;
				end
			end
			default: begin
				time_q <= time_q;
				id_q   <= id_q;
			end
		endcase
	end

endmodule

### rtl/timed_event_queue_unit.sv
// Timed event queue: sorted chain of DEPTH cells plus a current time.
// Insert and insert-if-future (only for a time after the current one) enter the chain in the accept
// cycle unless it is full. Remove, list and advance rotate the chain once, one entry per cycle
// unless a held entry must leave while the output is busy; the last beat carries tlast. One item at
// a time: the next item is taken once the last beat of the one before is in the output register.
// Reset clears entry count, current time and handshake state; cell contents are not reset.
module timed_event_queue_unit import timq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // command[2:0], time_value[34:3], event_id[50:35], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // entry_time[31:0], entry_id[47:32], now_time[79:48]
	output logic [2:0]  m_tuser,  // has_entry[0], fired[1], status[2]
	output logic        m_tlast
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	// input beat fields
	cmd_t                 in_cmd;
	logic [TIME_BITS-1:0] in_time;
	logic [ID_BITS-1:0]   in_id;

	assign in_cmd  = cmd_t'(s_tdata[2:0]);
	assign in_time = s_tdata[34:3];
	assign in_id   = s_tdata[50:35];

	// controller state
	state_t               state_q, state_d;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     steps_q;
	cmd_t                 cmd_q;
	logic [TIME_BITS-1:0] tv_q;
	logic [TIME_BITS-1:0] old_q;
	logic [TIME_BITS-1:0] now_q;
	logic                 status_q;

	// pending entry: held back one match so the final beat can carry tlast
	logic                 pend_valid_q;
	logic [TIME_BITS-1:0] pend_time_q;
	logic [ID_BITS-1:0]   pend_id_q;
	logic                 pend_fired_q;

	// output register
	logic                 out_valid_q;
	logic                 out_has_q;
	logic [TIME_BITS-1:0] out_time_q;
	logic [ID_BITS-1:0]   out_id_q;
	logic                 out_fired_q;
	logic                 out_status_q;
	logic [TIME_BITS-1:0] out_now_q;
	logic                 out_last_q;

	// chain
	logic [TIME_BITS-1:0] cell_time [DEPTH];
	logic [ID_BITS-1:0]   cell_id   [DEPTH];
	logic                 cell_le   [DEPTH];
	cell_ctrl_t           cell_ctrl;
	logic [IDX_W-1:0]     wp;

	// decoded controls
	logic accept, out_free, do_ins, full, ins_ok, ins_drop;
	logic match, emit, drop, step_go, push_pend, push_final;
	logic [TIME_BITS-1:0] head_time;
	logic [ID_BITS-1:0]   head_id;

	assign head_time = cell_time[0];
	assign head_id   = cell_id[0];
	assign out_free  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign full      = count_q == CNT_W'(DEPTH);
	assign do_ins    = (in_cmd == CMD_INSERT) ||
	                   ((in_cmd == CMD_INSERT_FUTURE) && (in_time > now_q));
	assign ins_ok    = do_ins && !full;
	assign ins_drop  = do_ins && full;
	// kept head goes to the last occupied slot after the shift
	assign wp        = IDX_W'(count_q - 1'b1);

	// classify the head entry against the command in flight
	always_comb begin
		case (cmd_q)
			CMD_REMOVE_AT: match = head_time == tv_q;
			CMD_LIST_ALL:  match = 1'b1;
			CMD_LIST_AT:   match = head_time == tv_q;
			CMD_ADVANCE:   match = (head_time >= old_q) && (head_time <= now_q);
			default:       match = 1'b0;
		endcase
	end

	assign emit = match && (cmd_q != CMD_REMOVE_AT);
	assign drop = match && ((cmd_q == CMD_REMOVE_AT) || (cmd_q == CMD_ADVANCE));

	// next state and handshake outputs
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		step_go    = 1'b0;
		push_pend  = 1'b0;
		push_final = 1'b0;
		cell_ctrl  = '{op: CELL_HOLD, keep: 1'b1};
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (in_cmd)
						CMD_INSERT, CMD_INSERT_FUTURE: begin
							if (ins_ok) begin
								cell_ctrl = '{op: CELL_INSERT, keep: 1'b1};
							end
							state_d = ST_FINISH;
						end
						CMD_REMOVE_AT, CMD_LIST_ALL, CMD_LIST_AT, CMD_ADVANCE: begin
							state_d = ST_SCAN;
						end
						default: begin
							state_d = ST_FINISH;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (steps_q == '0) begin
					state_d = ST_FINISH;
				end else begin
					// stall only when a held entry must leave and the output is busy
					step_go   = !(emit && pend_valid_q && !out_free);
					push_pend = step_go && emit && pend_valid_q;
					if (step_go) begin
						cell_ctrl = '{op: CELL_SHIFT, keep: !drop};
					end
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					push_final = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// command, count and time bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			steps_q      <= '0;
			now_q        <= '0;
			pend_valid_q <= 1'b0;
			status_q     <= 1'b0;
			cmd_q        <= CMD_INSERT;
		end else begin
			if (accept) begin
				cmd_q        <= in_cmd;
				status_q     <= ins_drop;
				pend_valid_q <= 1'b0;
				steps_q      <= count_q;
				if (ins_ok) begin
					count_q <= count_q + 1'b1;
				end
				if (in_cmd == CMD_ADVANCE) begin
					now_q <= now_q + in_time;
				end
			end else if (step_go) begin
				steps_q <= steps_q - 1'b1;
				if (drop) begin
					count_q <= count_q - 1'b1;
				end
				if (emit) begin
					pend_valid_q <= 1'b1;
				end
			end else if (push_final) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// payload held with the command; no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			tv_q  <= in_time;
			old_q <= now_q;
		end
		if (step_go && emit) begin
			pend_time_q  <= head_time;
			pend_id_q    <= head_id;
			pend_fired_q <= cmd_q == CMD_ADVANCE;
		end
	end

	// output register: one beat per push, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_pend || push_final) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_pend) begin
			out_has_q    <= 1'b1;
			out_time_q   <= pend_time_q;
			out_id_q     <= pend_id_q;
			out_fired_q  <= pend_fired_q;
			out_status_q <= 1'b0;
			out_now_q    <= now_q;
			out_last_q   <= 1'b0;
		end else if (push_final) begin
			// last held entry, or a bare acknowledgement when nothing was held
			out_has_q    <= pend_valid_q;
			out_time_q   <= pend_valid_q ? pend_time_q : '0;
			out_id_q     <= pend_valid_q ? pend_id_q : '0;
			out_fired_q  <= pend_valid_q && pend_fired_q;
			out_status_q <= status_q;
			out_now_q    <= now_q;
			out_last_q   <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_now_q, out_id_q, out_time_q};
	assign m_tuser  = {out_status_q, out_fired_q, out_has_q};
	assign m_tlast  = out_last_q;

	// the chain: cell 0 is the head, neighbors trade entries each shift
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                 left_le;
		logic [TIME_BITS-1:0] left_time, right_time;
		logic [ID_BITS-1:0]   left_id, right_id;

		if (i == 0) begin : g_first
			assign left_le   = 1'b1;
			assign left_time = in_time;
			assign left_id   = in_id;
		end else begin : g_inner_l
			assign left_le   = cell_le[i-1];
			assign left_time = cell_time[i-1];
			assign left_id   = cell_id[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			// the slot past the tail is never read; feed the head back
			assign right_time = head_time;
			assign right_id   = head_id;
		end else begin : g_inner_r
			assign right_time = cell_time[i+1];
			assign right_id   = cell_id[i+1];
		end

		timq_cell #(
			.DEPTH (DEPTH),
			.IDX   (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl),
			.count      (count_q),
			.wp         (wp),
			.ins_time   (in_time),
			.ins_id     (in_id),
			.left_le    (left_le),
			.left_time  (left_time),
			.left_id    (left_id),
			.right_time (right_time),
			.right_id   (right_id),
			.head_time  (head_time),
			.head_id    (head_id),
			.cell_time  (cell_time[i]),
			.cell_id    (cell_id[i]),
			.le         (cell_le[i])
		);
	end

endmodule

### tb/timq_schedule_checker.sv
// Checker for the timed event queue: watches both stream channels, predicts the
// result beats of every accepted command and compares them in order.
// Depends on timq_pkg for command codes and sizes.
`timescale 1ns / 100ps

module timq_schedule_checker import timq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,  // command[2:0], time_value[34:3], event_id[50:35], zero pad
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,  // entry_time[31:0], entry_id[47:32], now_time[79:48]
	input  logic [2:0]  m_tuser,  // has_entry[0], fired[1], status[2]
	input  logic        m_tlast,
	output int          fault_count,
	output int          beats_owed
);

	typedef struct {
		logic                 has_entry;
		logic [TIME_BITS-1:0] entry_time;
		logic [ID_BITS-1:0]   entry_id;
		logic                 fired;
		logic                 status;
		logic [TIME_BITS-1:0] now_time;
		logic                 last;
	} queue_beat_t;

	logic [TIME_BITS-1:0] sched_time[$];
	logic [ID_BITS-1:0]   sched_id[$];
	logic [TIME_BITS-1:0] sched_now;
	queue_beat_t          due_beats[$];

	function automatic void push_ack(input logic status);
		queue_beat_t b;
		b = '{1'b0, '0, '0, 1'b0, status, sched_now, 1'b1};
		due_beats.insert(due_beats.size(), b);
	endfunction

	function automatic logic place_entry(input logic [TIME_BITS-1:0] t,
			input logic [ID_BITS-1:0] id);
		int pos;
		if (sched_time.size() >= DEPTH_DEF)
			return 1'b1;
		pos = 0;
		// equal times keep arrival order: go past them
		while (pos < sched_time.size() && sched_time[pos] <= t)
			pos++;
		sched_time.insert(pos, t);
		sched_id.insert(pos, id);
		return 1'b0;
	endfunction

	function automatic void run_command(input logic [CMD_BITS-1:0] code,
			input logic [TIME_BITS-1:0] tv, input logic [ID_BITS-1:0] id);
		logic                 st;
		logic [TIME_BITS-1:0] old_now;
		logic [TIME_BITS-1:0] kept_time[$];
		logic [ID_BITS-1:0]   kept_id[$];
		int                   hits[$];
		queue_beat_t          b;
		st = 1'b0;
		case (code)
			CMD_INSERT: begin
				st = place_entry(tv, id);
				push_ack(st);
			end
			CMD_INSERT_FUTURE: begin
				if (tv > sched_now)
					st = place_entry(tv, id);
				push_ack(st);
			end
			CMD_REMOVE_AT: begin
				foreach (sched_time[i])
					if (sched_time[i] != tv) begin
						kept_time.insert(kept_time.size(), sched_time[i]);
						kept_id.insert(kept_id.size(), sched_id[i]);
					end
				sched_time = kept_time;
				sched_id = kept_id;
				push_ack(1'b0);
			end
			CMD_LIST_ALL, CMD_LIST_AT: begin
				foreach (sched_time[i])
					if (code == CMD_LIST_ALL || sched_time[i] == tv)
						hits.insert(hits.size(), i);
				foreach (hits[k]) begin
					b = '{1'b1, sched_time[hits[k]], sched_id[hits[k]], 1'b0, 1'b0,
						sched_now, k == hits.size() - 1};
					due_beats.insert(due_beats.size(), b);
				end
				if (hits.size() == 0)
					push_ack(1'b0);
			end
			CMD_ADVANCE: begin
				old_now = sched_now;
				sched_now = old_now + tv;
				// a wrapped sum leaves an empty window
				foreach (sched_time[i])
					if (sched_time[i] >= old_now && sched_time[i] <= sched_now)
						hits.insert(hits.size(), i);
					else begin
						kept_time.insert(kept_time.size(), sched_time[i]);
						kept_id.insert(kept_id.size(), sched_id[i]);
					end
				foreach (hits[k]) begin
					b = '{1'b1, sched_time[hits[k]], sched_id[hits[k]], 1'b1, 1'b0,
						sched_now, k == hits.size() - 1};
					due_beats.insert(due_beats.size(), b);
				end
				sched_time = kept_time;
				sched_id = kept_id;
				if (hits.size() == 0)
					push_ack(1'b0);
			end
			default: begin
				push_ack(1'b0);
			end
		endcase
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
			fault_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		queue_beat_t want;
		if (!arst_n) begin
			sched_time.delete();
			sched_id.delete();
			sched_now = '0;
			due_beats.delete();
			fault_count = 0;
			beats_owed <= 0;
		end else begin
			// compare the outgoing beat first; new predictions go to the back
			if (m_tvalid && m_tready) begin
				if (due_beats.size() == 0) begin
					$display("%0t: unexpected result beat, got data %0h user %0h last %0b",
						$time, m_tdata, m_tuser, m_tlast);
					fault_count++;
				end else begin
					want = due_beats.pop_front();
					check_field("has_entry", 32'(want.has_entry), 32'(m_tuser[0]));
					check_field("entry_time", want.entry_time, m_tdata[31:0]);
					check_field("entry_id", 32'(want.entry_id), 32'(m_tdata[47:32]));
					check_field("fired", 32'(want.fired), 32'(m_tuser[1]));
					check_field("status", 32'(want.status), 32'(m_tuser[2]));
					check_field("now_time", want.now_time, m_tdata[79:48]);
					check_field("last", 32'(want.last), 32'(m_tlast));
				end
			end
			if (s_tvalid && s_tready)
				run_command(s_tdata[2:0], s_tdata[34:3], s_tdata[50:35]);
			beats_owed <= due_beats.size();
		end
	end

endmodule

### tb/timed_event_queue_unit_test.sv
// Testbench top for the timed event queue: clock, reset, command stimulus and verdict.
// Depends on timq_pkg, timed_event_queue_unit and timq_schedule_checker.
`timescale 1ns / 100ps

module timed_event_queue_unit_test;
	import timq_pkg::*;

	// codes past the last command: the block must only acknowledge them
	localparam logic [CMD_BITS-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_BITS-1:0] CMD_SPARE_7 = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	int          fault_count;
	int          beats_owed;

	// when set, neither side idles
	logic                 steady = 1'b0;
	// running sum of advance deltas, used only to aim times near the present
	logic [TIME_BITS-1:0] now_est = '0;
	logic [TIME_BITS-1:0] recent_times[$];

	always #6 clk = ~clk;

	timed_event_queue_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	timq_schedule_checker schedule_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.fault_count (fault_count),
		.beats_owed  (beats_owed)
	);

	// stall the result channel about one cycle in five, except in the steady stretch
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 20);
	end

	// send one command beat: idle at random first, then hold valid until accepted
	task automatic issue(input logic [CMD_BITS-1:0] code, input logic [TIME_BITS-1:0] tv,
			input logic [ID_BITS-1:0] id);
		while (!steady && $urandom_range(99) < 20) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, id, tv, code};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (code == CMD_ADVANCE)
			now_est += tv;
		if (code == CMD_INSERT || code == CMD_INSERT_FUTURE) begin
			recent_times.insert(recent_times.size(), tv);
			if (recent_times.size() > 8)
				void'(recent_times.pop_front());
		end
	endtask

	// pick a time near the present, one seen recently, or any value at all
	function automatic logic [TIME_BITS-1:0] pick_time();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return $urandom;
		if (roll < 45 && recent_times.size() != 0)
			return recent_times[$urandom_range(recent_times.size() - 1)];
		return now_est + $urandom_range(0, 80);
	endfunction

	initial begin
		int                   roll;
		logic [TIME_BITS-1:0] tv;
		logic [TIME_BITS-1:0] delta;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, unknown codes, extremes, equal times, not-future
		issue(CMD_LIST_ALL, 32'd0, 16'd0);
		issue(CMD_ADVANCE, 32'd0, 16'd0);
		issue(CMD_SPARE_6, 32'hFFFF_FFFF, 16'hFFFF);
		issue(CMD_SPARE_7, 32'd5, 16'd1);
		issue(CMD_INSERT, 32'd0, 16'd0);
		issue(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		issue(CMD_INSERT, 32'd100, 16'h1234);
		issue(CMD_INSERT, 32'd100, 16'h5678);
		issue(CMD_INSERT_FUTURE, 32'd50, 16'hAAAA);
		issue(CMD_INSERT_FUTURE, 32'd0, 16'h5555);
		issue(CMD_LIST_ALL, 32'd0, 16'd0);
		issue(CMD_LIST_AT, 32'd100, 16'd0);
		issue(CMD_LIST_AT, 32'd7, 16'd0);
		issue(CMD_REMOVE_AT, 32'd100, 16'd0);
		issue(CMD_REMOVE_AT, 32'd12345, 16'd0);
		issue(CMD_ADVANCE, 32'd60, 16'd0);
		// fill the table, then push past full with both insert kinds
		for (int k = 0; k < 15; k++)
			issue(CMD_INSERT, 32'(1000 + $urandom_range(0, 40)), 16'($urandom));
		issue(CMD_INSERT, 32'd500, 16'hBEEF);
		issue(CMD_INSERT_FUTURE, 32'd2000, 16'hCAFE);
		issue(CMD_LIST_ALL, 32'd0, 16'd0);
		// wrapping advance fires nothing; the next one fires every entry but the one at the top of the range
		issue(CMD_ADVANCE, 32'hFFFF_FFF0, 16'd0);
		issue(CMD_ADVANCE, 32'hFFFF_FFB3, 16'd0);
		issue(CMD_LIST_ALL, 32'd0, 16'd0);

		// random: mostly inserts aimed near the present, with advances to fire them
		for (int n = 0; n < 133; n++) begin
			steady = (n >= 60 && n < 110);
			roll = $urandom_range(99);
			tv = pick_time();
			if (roll < 40)
				issue(CMD_INSERT, tv, 16'($urandom));
			else if (roll < 50)
				issue(CMD_INSERT_FUTURE, ($urandom_range(1) != 0) ? tv :
					now_est - $urandom_range(0, 3), 16'($urandom));
			else if (roll < 58)
				issue(CMD_REMOVE_AT, tv, 16'($urandom));
			else if (roll < 66)
				issue(CMD_LIST_ALL, tv, 16'($urandom));
			else if (roll < 76)
				issue(CMD_LIST_AT, tv, 16'($urandom));
			else if (roll < 95) begin
				delta = ($urandom_range(11) == 0) ? $urandom : $urandom_range(0, 40);
				issue(CMD_ADVANCE, delta, 16'($urandom));
			end else
				issue(($urandom_range(1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7, tv,
					16'($urandom));
		end
		steady = 1'b0;
		s_tvalid <= 1'b0;

		// let the count of owed beats settle, drain them, then give the block time to misbehave
		@(posedge clk);
		while (beats_owed != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fault_count == 0)
			$display("timed_event_queue_unit_test: PASS");
		else
			$display("timed_event_queue_unit_test: FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timed_event_queue_unit_test: FAIL");
		$finish;
	end

endmodule
